### rtl/constrained_nearest_waypoint_macros.svh
// ----------------------------------------------------------------------------
// Constrained nearest waypoint: assertion macros
// Shared concurrent assertion forms, clocked on the given clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONSTRAINED_NEAREST_WAYPOINT_MACROS_SVH
`define CONSTRAINED_NEAREST_WAYPOINT_MACROS_SVH

// Same-cycle implication
`define CNW_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication
`define CNW_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/cnw_pkg.sv
// ----------------------------------------------------------------------------
// Constrained nearest waypoint package
// Table sizing, field layout, command codes and the squared-distance function.
// ----------------------------------------------------------------------------
package cnw_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Arithmetic widths
    localparam int CRD_W = 8;
    localparam int BND_W = 10;
    localparam int DST_W = 17;
    localparam int BSQ_W = 2 * BND_W;
    localparam int PNT_W = 2 * CRD_W;

    // Near radius, squared
    localparam logic [DST_W-1:0] NEAR_LIMIT_SQ = DST_W'(100);

    // Command codes
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Stream widths
    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    // Request field offsets in s_tdata
    localparam int OFS_PX = 0;
    localparam int OFS_PY = 8;
    localparam int OFS_SX = 16;
    localparam int OFS_SY = 24;
    localparam int OFS_TX = 32;
    localparam int OFS_TY = 40;
    localparam int OFS_SB = 48;
    localparam int OFS_DX = 58;
    localparam int OFS_DY = 66;

    // Squared Euclidean distance between two points
    function automatic logic [DST_W-1:0] dist_sq(input logic [CRD_W-1:0] ax,
                                                 input logic [CRD_W-1:0] ay,
                                                 input logic [CRD_W-1:0] bx,
                                                 input logic [CRD_W-1:0] by);
        logic [CRD_W-1:0]   dx;
        logic [CRD_W-1:0]   dy;
        logic [2*CRD_W-1:0] sqx;
        logic [2*CRD_W-1:0] sqy;
        dx  = (ax > bx) ? (ax - bx) : (bx - ax);
        dy  = (ay > by) ? (ay - by) : (by - ay);
        sqx = PNT_W'(dx) * PNT_W'(dx);
        sqy = PNT_W'(dy) * PNT_W'(dy);
        return DST_W'(sqx) + DST_W'(sqy);
    endfunction

endpackage

### rtl/cnw_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module cnw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/constrained_nearest_waypoint.sv
// Latency: clear and append give their result in the cycle after the request is taken.
// Query: a setup state, then per stored point a source check, a target check if near,
//   and if kept 9 square-root steps; then the result is loaded; one request at a time.
// Throughput is set by the single table read port and the shared distance unit.
// Reset: synchronous, active-low aresetn clears sequencer, point count and output valid;
// table contents are left undefined, no clearing pass is made.
// ----------------------------------------------------------------------------
// Constrained nearest waypoint search
// Stores waypoints in a RAM and answers nearest-to-target queries restricted
// to points near a source, using one distance unit and a bit-serial square root.
// ----------------------------------------------------------------------------
module constrained_nearest_waypoint
    import cnw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_x, point_y, source_x, source_y, target_x, target_y, start_bound,
    // default_x, default_y, 6 zero bits
    input  logic [S_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [S_USER_W-1:0]  s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found_x, found_y
    output logic [M_DATA_W-1:0]  m_tdata,
    // found, accepted
    output logic [M_USER_W-1:0]  m_tuser
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_SRC  = 3'd2;
    localparam logic [2:0] ST_TGT  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [DST_W-1:0] SQRT_TOP = DST_W'(1) << (DST_W - 1);

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [M_USER_W-1:0] m_user_reg, m_user_next;
    logic [CRD_W-1:0]    src_x_reg, src_x_next, src_y_reg, src_y_next;
    logic [CRD_W-1:0]    tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic [CRD_W-1:0]    res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                found_reg, found_next;
    logic [BND_W-1:0]    bnd_reg, bnd_next;
    logic [BSQ_W-1:0]    bsq_reg, bsq_next;
    logic [DST_W-1:0]    d_reg, d_next;
    logic [DST_W-1:0]    v_reg, v_next;
    logic [DST_W-1:0]    root_reg, root_next;
    logic [DST_W-1:0]    bit_reg, bit_next;

    logic                s_fire;
    logic                out_free;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [PNT_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [PNT_W-1:0]    ram_rdata;
    logic [CRD_W-1:0]    pt_x, pt_y;
    logic [CRD_W-1:0]    du_ax, du_ay;
    logic [DST_W-1:0]    du_dist;
    logic [CNT_W-1:0]    idx_inc;
    logic [DST_W:0]      sq_sum;
    logic [DST_W-1:0]    sq_rem;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Point table
    cnw_ram #(
        .WIDTH (PNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_next[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign pt_x = ram_rdata[CRD_W-1:0];
    assign pt_y = ram_rdata[PNT_W-1:CRD_W];

    // Shared distance unit: target in the target check, source otherwise
    assign du_ax   = (state_reg == ST_TGT) ? tgt_x_reg : src_x_reg;
    assign du_ay   = (state_reg == ST_TGT) ? tgt_y_reg : src_y_reg;
    assign du_dist = dist_sq(du_ax, du_ay, pt_x, pt_y);

    // Square-root step operands
    assign sq_sum  = {1'b0, root_reg} + {1'b0, bit_reg};
    assign sq_rem  = v_reg - sq_sum[DST_W-1:0];
    assign idx_inc = idx_reg + CNT_W'(1);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        src_x_next   = src_x_reg;
        src_y_next   = src_y_reg;
        tgt_x_next   = tgt_x_reg;
        tgt_y_next   = tgt_y_reg;
        res_x_next   = res_x_reg;
        res_y_next   = res_y_reg;
        found_next   = found_reg;
        bnd_next     = bnd_reg;
        bsq_next     = bsq_reg;
        d_next       = d_reg;
        v_next       = v_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[IDX_W-1:0];
        ram_wdata    = s_tdata[OFS_PX +: PNT_W];
        ram_re       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    m_data_next = '0;
                    m_user_next = '0;
                    unique case (s_tuser)
                        KIND_CLEAR: begin
                            cnt_next     = '0;
                            m_valid_next = 1'b1;
                        end
                        KIND_APPEND: begin
                            // Store when there is room, report either way
                            if (cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                                ram_we         = 1'b1;
                                cnt_next       = cnt_reg + CNT_W'(1);
                                m_user_next[1] = 1'b1;
                            end
                            m_valid_next = 1'b1;
                        end
                        KIND_QUERY: begin
                            src_x_next = s_tdata[OFS_SX +: CRD_W];
                            src_y_next = s_tdata[OFS_SY +: CRD_W];
                            tgt_x_next = s_tdata[OFS_TX +: CRD_W];
                            tgt_y_next = s_tdata[OFS_TY +: CRD_W];
                            bnd_next   = s_tdata[OFS_SB +: BND_W];
                            res_x_next = s_tdata[OFS_DX +: CRD_W];
                            res_y_next = s_tdata[OFS_DY +: CRD_W];
                            found_next = 1'b0;
                            state_next = ST_INIT;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                // Square the start bound, fetch the first point if the table is not empty
                bsq_next = BSQ_W'(bnd_reg) * BSQ_W'(bnd_reg);
                idx_next = '0;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_SRC;
                end
            end
            ST_SRC: begin
                if (du_dist < NEAR_LIMIT_SQ) begin
                    state_next = ST_TGT;
                end else if (idx_inc == cnt_reg) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next = idx_inc;
                    ram_re   = 1'b1;
                end
            end
            ST_TGT: begin
                if (BSQ_W'(du_dist) < bsq_reg) begin
                    // Keep the point and start the root of its distance
                    res_x_next = pt_x;
                    res_y_next = pt_y;
                    found_next = 1'b1;
                    d_next     = du_dist;
                    v_next     = du_dist;
                    root_next  = '0;
                    bit_next   = SQRT_TOP;
                    state_next = ST_SQRT;
                end else if (idx_inc == cnt_reg) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next   = idx_inc;
                    ram_re     = 1'b1;
                    state_next = ST_SRC;
                end
            end
            ST_SQRT: begin
                // One restoring square-root digit per cycle
                if ({1'b0, v_reg} >= sq_sum) begin
                    v_next    = sq_rem;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    // New bound squared is the distance less the remainder
                    bsq_next = BSQ_W'(d_reg - v_next);
                    if (idx_inc == cnt_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        idx_next   = idx_inc;
                        ram_re     = 1'b1;
                        state_next = ST_SRC;
                    end
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_y_reg, res_x_reg};
                    m_user_next  = {1'b0, found_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        src_x_reg  <= src_x_next;
        src_y_reg  <= src_y_next;
        tgt_x_reg  <= tgt_x_next;
        tgt_y_reg  <= tgt_y_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        found_reg  <= found_next;
        bnd_reg    <= bnd_next;
        bsq_reg    <= bsq_next;
        d_reg      <= d_next;
        v_reg      <= v_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
    end

endmodule

### rtl/cnw_checker.sv
// ----------------------------------------------------------------------------
// Constrained nearest waypoint port checker
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
`include "constrained_nearest_waypoint_macros.svh"

module cnw_checker
    import cnw_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [S_USER_W-1:0] s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // Hold a stalled result
    `CNW_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `CNW_ASSERT_NXT(a_out_data_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `CNW_ASSERT_NXT(a_out_user_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tuser))

    // Take a request only when the output register can take its result
    `CNW_ASSERT_IMP(a_ready_room, aclk, aresetn, s_tready, !m_tvalid || m_tready)

    // A result is never both a query hit and a stored append
    `CNW_ASSERT_IMP(a_flags_excl, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))

endmodule

bind constrained_nearest_waypoint cnw_checker u_cnw_checker (.*);
